### hdl/pfr_pkg.sv
// pfr_pkg: shared types and constants for the page framebuffer rasterizer
// no dependencies
package pfr_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_RECT  = 3'd3,
    CMD_FILL  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] x2;
    logic [7:0] y2;
    logic       color;
    logic [9:0] addr;
  } pfr_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIXEL,
    ST_LINE,
    ST_RTOP,
    ST_RBOT,
    ST_RLEFT,
    ST_RRIGHT,
    ST_FILL,
    ST_READ,
    ST_RDWAIT,
    ST_DONE
  } pfr_state_t;

endpackage

### hdl/page_framebuffer_rasterizer.sv
// each command draws its pixels one after another, one pixel read-modify-write in flight at a time;
// clear sweeps the whole store to zero, read returns one byte of the store
// throughput: one command at a time in the drawing sequencer; a two-entry queue buffers input
// the frame store has one write port, shared by the pixel writes and the clear sweep
// reset: synchronous active low; the store is swept to zero, during which no command
// is started; registers return to width 128, height 64
module page_framebuffer_rasterizer #(
  parameter int STORE_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [7:0] in_coord_x1,
  input  logic [7:0] in_coord_y1,
  input  logic [7:0] in_coord_x2,
  input  logic [7:0] in_coord_y2,
  input  logic       in_pixel_color,
  input  logic [9:0] in_read_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import pfr_pkg::*;

  pfr_cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic [7:0] w_r;
  logic [6:0] h_r;

  assign in_cmd = '{command: in_command, x1: in_coord_x1, y1: in_coord_y1,
                    x2: in_coord_x2, y2: in_coord_y2, color: in_pixel_color,
                    addr: in_read_address};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 8'd128;
      h_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) w_r <= cfg_data;
      else h_r <= cfg_data[6:0];
    end
  end

  pfr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  pfr_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .disp_w(w_r), .disp_h(h_r),
    .out_valid, .out_stall, .out_read_data
  );
endmodule

### hdl/pfr_front.sv
// pfr_front: input acceptance and a two-entry command queue
// depends on pfr_pkg
module pfr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  pfr_pkg::pfr_cmd_t in_cmd,
  output logic            q_valid,
  input  logic            q_pop,
  output pfr_pkg::pfr_cmd_t q_cmd
);
  import pfr_pkg::*;

  pfr_cmd_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop && q_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop && q_valid);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !(q_pop && q_valid))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !(q_pop && q_valid)) |=> cnt_r == 2'd2)
    else $error("full queue lost an entry");
endmodule

### hdl/pfr_back.sv
// pfr_back: drawing sequencer with frame store and output register
// depends on pfr_pkg
module pfr_back #(
  parameter int STORE_BYTES = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  pfr_pkg::pfr_cmd_t q_cmd,
  input  logic [7:0]      disp_w,
  input  logic [6:0]      disp_h,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_read_data
);
  import pfr_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_r;

  pfr_state_t st_r, st_nxt;
  pfr_cmd_t   c_r, c_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [7:0] x_r, x_nxt, y_r, y_nxt, i_r, i_nxt, j_r, j_nxt;
  logic signed [9:0] err_r, err_nxt;
  logic [7:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [7:0] od_r, od_nxt;
  logic       ov_r, ov_nxt;
  // set while the sweep after reset runs, which produces no result
  logic       boot_r, boot_nxt;

  // pixel read-modify-write pipeline: stage 1 read, stage 2 write
  logic        px_go;
  logic [7:0]  px_x, px_y;
  logic        p1_v_r;
  logic [AW-1:0] p1_a_r;
  logic [2:0]  p1_b_r;
  logic        p1_c_r;
  logic [15:0] paddr;
  logic        hit;
  logic [7:0]  rmw_q;
  logic        wb_v_r;
  logic [AW-1:0] wb_a_r;
  logic [7:0]  wb_d_r;
  logic [7:0]  cur;

  always_comb begin
    paddr = 16'(px_x) + 16'(disp_w) * 16'(px_y[7:3]);
    hit = px_go && (px_x < disp_w) && ({1'b0, px_y} < {2'b0, disp_h})
          && (paddr < 16'(STORE_BYTES));
  end

  // clear sweep shares the write port; the pixel read bypasses a pending write
  logic          clr_we;
  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[clr_r[AW-1:0]] <= 8'd0;
    end else if (wb_v_r) begin
      mem[wb_a_r] <= wb_d_r;
    end
    rmw_q   <= mem[paddr[AW-1:0]];
    rdata_r <= mem[AW'(c_r.addr)];
  end

  always_comb begin
    cur = (wb_v_r && wb_a_r == p1_a_r) ? wb_d_r : rmw_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      wb_v_r <= 1'b0;
    end else begin
      p1_v_r <= hit;
      wb_v_r <= p1_v_r;
    end
    p1_a_r <= paddr[AW-1:0];
    p1_b_r <= px_y[2:0];
    p1_c_r <= c_r.color;
    wb_a_r <= p1_a_r;
    wb_d_r <= p1_c_r ? (cur | (8'd1 << p1_b_r)) : (cur & ~(8'd1 << p1_b_r));
  end

  // one pixel in flight at a time keeps read after write simple
  logic busy_px;
  assign busy_px = p1_v_r || wb_v_r;

  logic signed [9:0] e2;
  logic step_x, step_y;

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; clr_nxt = clr_r;
    x_nxt = x_r; y_nxt = y_r; i_nxt = i_r; j_nxt = j_r;
    err_nxt = err_r; dx_nxt = dx_r; dy_nxt = dy_r;
    od_nxt = od_r; ov_nxt = ov_r; boot_nxt = boot_r;
    q_pop = 1'b0; px_go = 1'b0; px_x = x_r; px_y = y_r; clr_we = 1'b0;
    e2 = err_r;
    step_x = e2 > -$signed({2'b0, dx_r});
    step_y = e2 < $signed({2'b0, dy_r});
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid && !busy_px) begin
          q_pop = 1'b1;
          c_nxt = q_cmd;
          x_nxt = q_cmd.x1; y_nxt = q_cmd.y1; i_nxt = 8'd0; j_nxt = 8'd0;
          clr_nxt = '0;
          dx_nxt = (q_cmd.x2 > q_cmd.x1) ? q_cmd.x2 - q_cmd.x1 : q_cmd.x1 - q_cmd.x2;
          dy_nxt = (q_cmd.y2 > q_cmd.y1) ? q_cmd.y2 - q_cmd.y1 : q_cmd.y1 - q_cmd.y2;
          if (dx_nxt > dy_nxt) err_nxt = 10'($signed({2'b0, dx_nxt[7:1]}));
          else err_nxt = -10'($signed({2'b0, dy_nxt[7:1]}));
          case (q_cmd.command)
            CMD_CLEAR: st_nxt = ST_CLEAR;
            CMD_PIXEL: st_nxt = ST_PIXEL;
            CMD_LINE:  st_nxt = ST_LINE;
            // zero width still draws both side columns
            CMD_RECT:  st_nxt = (q_cmd.x2 != 8'd0) ? ST_RTOP :
                                (q_cmd.y2 != 8'd0) ? ST_RLEFT : ST_DONE;
            CMD_FILL:  st_nxt = (q_cmd.x2 == 8'd0 || q_cmd.y2 == 8'd0) ? ST_DONE : ST_FILL;
            CMD_READ:  st_nxt = ST_READ;
            default:   st_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        clr_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(STORE_BYTES - 1)) begin
          st_nxt = boot_r ? ST_IDLE : ST_DONE;
          boot_nxt = 1'b0;
        end
      end
      ST_PIXEL: begin
        px_go = 1'b1; st_nxt = ST_DONE;
      end
      ST_LINE: if (!busy_px) begin
        px_go = 1'b1;
        if (x_r == c_r.x2 && y_r == c_r.y2) st_nxt = ST_DONE;
        else begin
          if (step_x) begin
            err_nxt = err_r - $signed({2'b0, dy_r});
            x_nxt = (c_r.x1 < c_r.x2) ? x_r + 8'd1 : x_r - 8'd1;
          end
          if (step_y) begin
            err_nxt = err_nxt + $signed({2'b0, dx_r});
            y_nxt = (c_r.y1 < c_r.y2) ? y_r + 8'd1 : y_r - 8'd1;
          end
        end
      end
      ST_RTOP, ST_RBOT: if (!busy_px) begin
        px_go = 1'b1;
        px_x = c_r.x1 + i_r;
        px_y = (st_r == ST_RTOP) ? c_r.y1 : c_r.y1 + c_r.y2 - 8'd1;
        i_nxt = i_r + 8'd1;
        if (i_r == c_r.x2 - 8'd1) begin
          i_nxt = 8'd0;
          if (st_r == ST_RTOP) st_nxt = ST_RBOT;
          else st_nxt = (c_r.y2 == 8'd0) ? ST_DONE : ST_RLEFT;
        end
      end
      ST_RLEFT, ST_RRIGHT: if (!busy_px) begin
        px_go = 1'b1;
        px_x = (st_r == ST_RLEFT) ? c_r.x1 : c_r.x1 + c_r.x2 - 8'd1;
        px_y = c_r.y1 + i_r;
        i_nxt = i_r + 8'd1;
        if (i_r == c_r.y2 - 8'd1) begin
          i_nxt = 8'd0;
          st_nxt = (st_r == ST_RLEFT) ? ST_RRIGHT : ST_DONE;
        end
      end
      ST_FILL: if (!busy_px) begin
        px_go = 1'b1;
        px_x = c_r.x1 + i_r;
        px_y = c_r.y1 + j_r;
        j_nxt = j_r + 8'd1;
        if (j_r == c_r.y2 - 8'd1) begin
          j_nxt = 8'd0;
          i_nxt = i_r + 8'd1;
          if (i_r == c_r.x2 - 8'd1) st_nxt = ST_DONE;
        end
      end
      ST_READ: if (!busy_px) st_nxt = ST_RDWAIT;
      ST_RDWAIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = (32'(c_r.addr) < 32'(STORE_BYTES)) ? rdata_r : 8'd0;
          st_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1; od_nxt = 8'd0; st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
      clr_r <= '0;
      ov_r <= 1'b0;
      c_r <= '0;
      boot_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
      c_r <= c_nxt;
      boot_r <= boot_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; i_r <= i_nxt; j_r <= j_nxt;
    err_r <= err_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt; od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_read_data = od_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> ov_r && $stable(od_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == ST_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_we |-> !wb_v_r)
    else $error("clear sweep collides with pixel write");
endmodule
